/* rtl/sqef_pkg.sv */
// ----------------------------------------------------------------------------
// sqef_pkg
// Shared widths, constants and the item type of the sign quantizer with
// error feedback.
// ----------------------------------------------------------------------------
package sqef_pkg;

  localparam int IDX_W          = 16;
  localparam int HALF_W         = 16;
  localparam int SCALE_W        = 32;
  localparam int STEP_W         = 31;
  localparam int Q_W            = 32;

  localparam int TAIL_DEPTH_DEF = 65536;

  // decoupling queue between front and back, and the result queue
  localparam int MID_DEPTH      = 4;
  localparam int OUT_DEPTH      = 4;
  localparam int OUT_CW         = $clog2(OUT_DEPTH + 1);

  // front stages plus back execute stage, used for occupancy bounds
  localparam int FRONT_STAGES   = 2;
  localparam int BACK_STAGES    = 1;

  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [Q_W-1:0] Q_MAX = 32'h7fff_ffff;

  // scaled delta with its element, ready for the residual update
  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [Q_W-1:0]   delta;
    logic [STEP_W-1:0]       step;
  } sqef_item_t;

endpackage

/* rtl/sqef_fifo.sv */
// ----------------------------------------------------------------------------
// sqef_fifo
// Small register queue with occupancy count, head shown while not empty.
// ----------------------------------------------------------------------------
module sqef_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  input  logic                         pop,
  output logic [WIDTH-1:0]             head_data,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign count     = count_r;
  assign head_data = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/sqef_front.sv */
// ----------------------------------------------------------------------------
// sqef_front
// Accepts items, classifies the fp16 delta, scales it and reduces the
// element index to a store address. Two stages, no dependence on state.
// ----------------------------------------------------------------------------
module sqef_front #(
  parameter int TAIL_DEPTH = sqef_pkg::TAIL_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sqef_pkg::IDX_W-1:0]           in_idx,
  input  logic [sqef_pkg::HALF_W-1:0]          in_half,
  input  logic [sqef_pkg::SCALE_W-1:0]         in_scale,
  input  logic [sqef_pkg::STEP_W-1:0]          in_step,
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output sqef_pkg::sqef_item_t                 dn_item,
  output logic [$clog2(TAIL_DEPTH)-1:0]        dn_addr
);

  import sqef_pkg::*;

  localparam int AW = $clog2(TAIL_DEPTH);
  localparam logic [4:0] EXP_SPECIAL = 5'h1f;
  localparam int PROD_W = Q_W + SCALE_W;

  // stage 1: magnitude of the converted delta
  logic                 s1_v_r;
  logic                 s1_neg_r;
  logic [Q_W-1:0]       s1_mag_r;
  logic [SCALE_W-1:0]   s1_scale_r;
  logic [STEP_W-1:0]    s1_step_r;
  logic [IDX_W-1:0]     s1_idx_r;

  // stage 2: full product
  logic                 s2_v_r;
  logic                 s2_neg_r;
  logic [PROD_W-1:0]    s2_prod_r;
  logic [STEP_W-1:0]    s2_step_r;
  logic [IDX_W-1:0]     s2_idx_r;
  logic [AW-1:0]        s2_addr_r;
  logic [AW-1:0]        s2_addr_nxt;

  logic                 s1_adv;
  logic                 s2_adv;

  logic                 h_neg;
  logic [4:0]           h_ex;
  logic [9:0]           h_man;
  logic [Q_W-1:0]       h_lim;
  logic [40:0]          h_sh;
  logic [Q_W-1:0]       mag_nxt;

  logic [PROD_W-1:0]    rnd;
  logic [39:0]          rmag;
  logic [39:0]          rmag_neg;
  logic [Q_W-1:0]       delta_q;

  assign s2_adv   = !s2_v_r || dn_ready;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;
  assign dn_valid = s2_v_r;

  // fp16 to Q8.24 magnitude, NaN as zero, large values and infinities clipped
  always_comb begin
    h_neg = in_half[15];
    h_ex  = in_half[14:10];
    h_man = in_half[9:0];
    h_lim = h_neg ? Q_MIN : Q_MAX;
    h_sh  = 41'(11'd1024 + {1'b0, h_man}) << (h_ex - 5'd1);
    if (h_ex == EXP_SPECIAL) begin
      mag_nxt = (h_man != '0) ? '0 : h_lim;
    end else if (h_ex == '0) begin
      mag_nxt = Q_W'(h_man);
    end else if (h_sh > 41'(h_lim)) begin
      mag_nxt = h_lim;
    end else begin
      mag_nxt = h_sh[Q_W-1:0];
    end
  end

  // index reduction to the store depth
  generate
    if (TAIL_DEPTH >= (2 ** IDX_W)) begin : g_direct
      assign s2_addr_nxt = AW'(s1_idx_r);
    end else begin : g_recip
      // exact floor division by reciprocal for every index of IDX_W bits
      localparam int          SH     = IDX_W + AW;
      localparam int          M_W    = IDX_W + 2;
      localparam int          QP_W   = IDX_W + M_W;
      localparam longint unsigned M_L =
        ((64'd1 << SH) + 64'(TAIL_DEPTH) - 64'd1) / 64'(TAIL_DEPTH);
      localparam logic [M_W-1:0]   RECIP = M_W'(M_L);
      localparam logic [IDX_W-1:0] DIVV  = IDX_W'(TAIL_DEPTH);

      logic [QP_W-1:0]  qp_r;
      logic [IDX_W-1:0] quot;
      logic [IDX_W-1:0] rem;

      always_ff @(posedge clk) begin
        if (s1_adv) begin
          qp_r <= QP_W'(in_idx) * QP_W'(RECIP);
        end
      end

      assign quot        = IDX_W'(qp_r >> SH);
      assign rem         = s1_idx_r - IDX_W'(32'(quot) * 32'(DIVV));
      assign s2_addr_nxt = AW'(rem);
    end
  endgenerate

  // round half away from zero, back to Q8.24, saturate
  always_comb begin
    rnd      = s2_prod_r + PROD_W'(64'h0080_0000);
    rmag     = rnd[63:24];
    rmag_neg = 40'd0 - rmag;
    if (s2_neg_r) begin
      delta_q = (rmag > 40'(Q_MIN)) ? Q_MIN : rmag_neg[Q_W-1:0];
    end else begin
      delta_q = (rmag > 40'(Q_MAX)) ? Q_MAX : rmag[Q_W-1:0];
    end
  end

  assign dn_item.idx   = s2_idx_r;
  assign dn_item.delta = delta_q;
  assign dn_item.step  = s2_step_r;
  assign dn_addr       = s2_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= in_valid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_neg_r   <= h_neg;
      s1_mag_r   <= mag_nxt;
      s1_scale_r <= in_scale;
      s1_step_r  <= in_step;
      s1_idx_r   <= in_idx;
    end
    if (s2_adv) begin
      s2_neg_r  <= s1_neg_r;
      s2_prod_r <= PROD_W'(s1_mag_r) * PROD_W'(s1_scale_r);
      s2_step_r <= s1_step_r;
      s2_idx_r  <= s1_idx_r;
      s2_addr_r <= s2_addr_nxt;
    end
  end

endmodule

/* rtl/sqef_back.sv */
// ----------------------------------------------------------------------------
// sqef_back
// Residual store read-modify-write: adds the stored residual, takes the
// sign, applies the step and writes back. Clears the store after reset.
// ----------------------------------------------------------------------------
module sqef_back #(
  parameter int TAIL_DEPTH = sqef_pkg::TAIL_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  sqef_pkg::sqef_item_t                 q_item,
  input  logic [$clog2(TAIL_DEPTH)-1:0]        q_addr,
  output logic                                 q_pop,
  input  logic [sqef_pkg::OUT_CW-1:0]          out_count,
  output logic                                 res_push,
  output logic                                 res_sign,
  output logic [sqef_pkg::IDX_W-1:0]           res_idx,
  output logic                                 clearing
);

  import sqef_pkg::*;

  localparam int AW = $clog2(TAIL_DEPTH);

  logic [Q_W-1:0]          store_mem [TAIL_DEPTH];
  logic [Q_W-1:0]          rd_data_r;

  logic                    clear_r;
  logic [AW-1:0]           clr_cnt_r;

  logic                    e_v_r;
  sqef_item_t              e_item_r;
  logic [AW-1:0]           e_addr_r;

  // last write, for the read that raced it
  logic                    lw_v_r;
  logic [AW-1:0]           lw_addr_r;
  logic [Q_W-1:0]          lw_data_r;

  logic [OUT_CW:0]         room_used;
  logic signed [Q_W-1:0]   resid;
  logic signed [Q_W:0]     sum_w;
  logic signed [Q_W-1:0]   sum;
  logic                    neg;
  logic signed [Q_W:0]     next_w;
  logic [Q_W-1:0]          next_res;

  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [Q_W-1:0]          wr_data;

  // credit towards the result queue so the execute stage never stalls
  assign room_used = (OUT_CW + 1)'(out_count) + (OUT_CW + 1)'(e_v_r);
  assign q_pop     = !q_empty && !clear_r && (room_used < (OUT_CW + 1)'(OUT_DEPTH));
  assign clearing  = clear_r;

  always_comb begin
    resid = (lw_v_r && (lw_addr_r == e_addr_r)) ? lw_data_r : rd_data_r;
    sum_w = {resid[Q_W-1], resid} + {e_item_r.delta[Q_W-1], e_item_r.delta};
    if (sum_w[Q_W] != sum_w[Q_W-1]) begin
      sum = sum_w[Q_W] ? Q_MIN : Q_MAX;
    end else begin
      sum = sum_w[Q_W-1:0];
    end
    neg = sum[Q_W-1];
    if (neg) begin
      next_w = {sum[Q_W-1], sum} + (Q_W + 1)'(e_item_r.step);
    end else begin
      next_w = {sum[Q_W-1], sum} - (Q_W + 1)'(e_item_r.step);
    end
    next_res = next_w[Q_W-1:0];
  end

  assign wr_en   = clear_r || e_v_r;
  assign wr_addr = clear_r ? clr_cnt_r : e_addr_r;
  assign wr_data = clear_r ? '0 : next_res;

  assign res_push = e_v_r;
  assign res_sign = neg;
  assign res_idx  = e_item_r.idx;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= store_mem[q_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r   <= 1'b1;
      clr_cnt_r <= '0;
      e_v_r     <= 1'b0;
      lw_v_r    <= 1'b0;
    end else begin
      if (clear_r) begin
        if (clr_cnt_r == AW'(TAIL_DEPTH - 1)) begin
          clear_r <= 1'b0;
        end
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      e_v_r  <= q_pop;
      lw_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      e_item_r <= q_item;
      e_addr_r <= q_addr;
    end
    if (e_v_r) begin
      lw_addr_r <= e_addr_r;
      lw_data_r <= next_res;
    end
  end

endmodule

/* rtl/sign_quantize_error_feedback.sv */
// ----------------------------------------------------------------------------
// sign_quantize_error_feedback
// One-bit sign quantizer with per-element error feedback residuals.
// ----------------------------------------------------------------------------
// path: front stages s1 and s2, the middle queue, the execute stage, the result queue
// throughput: one item per cycle, set by the pipelined residual update, while results
//   are popped (one store read and one write each cycle, the racing read forwarded)
// reset: synchronous; afterwards full stays high while the residual store is
//   swept to zero, one entry a cycle
module sign_quantize_error_feedback #(
  parameter int TAIL_DEPTH = sqef_pkg::TAIL_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic [sqef_pkg::IDX_W-1:0]         in_element_index,
  input  logic [sqef_pkg::HALF_W-1:0]        in_delta_half,
  input  logic [sqef_pkg::SCALE_W-1:0]       in_row_scale,
  input  logic [sqef_pkg::STEP_W-1:0]        in_step,
  output logic                               empty,
  input  logic                               pop,
  output logic                               out_sign_bit,
  output logic [sqef_pkg::IDX_W-1:0]         out_element_index_out
);

  import sqef_pkg::*;

  localparam int AW    = $clog2(TAIL_DEPTH);
  localparam int MID_W = $bits(sqef_item_t) + AW;
  localparam int RES_W = IDX_W + 1;

  logic                     front_ready;
  logic                     front_in_valid;
  logic                     dn_valid;
  sqef_item_t               dn_item;
  logic [AW-1:0]            dn_addr;

  logic                     mid_full;
  logic                     mid_empty;
  logic [MID_W-1:0]         mid_head;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  logic                     mid_pop;

  logic                     res_push;
  logic                     res_sign;
  logic [IDX_W-1:0]         res_idx;
  logic [RES_W-1:0]         out_head;
  logic                     out_full;
  logic [OUT_CW-1:0]        out_count;
  logic                     clearing;

  assign full           = !front_ready || clearing;
  assign front_in_valid = push && !full;

  sqef_front #(
    .TAIL_DEPTH (TAIL_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (front_in_valid),
    .in_ready (front_ready),
    .in_idx   (in_element_index),
    .in_half  (in_delta_half),
    .in_scale (in_row_scale),
    .in_step  (in_step),
    .dn_valid (dn_valid),
    .dn_ready (!mid_full),
    .dn_item  (dn_item),
    .dn_addr  (dn_addr)
  );

  sqef_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (dn_valid),
    .push_data ({dn_item, dn_addr}),
    .pop       (mid_pop),
    .head_data (mid_head),
    .full      (mid_full),
    .empty     (mid_empty),
    .count     (mid_count)
  );

  sqef_back #(
    .TAIL_DEPTH (TAIL_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (mid_empty || (mid_count == '0)),
    .q_item    (mid_head[MID_W-1:AW]),
    .q_addr    (mid_head[AW-1:0]),
    .q_pop     (mid_pop),
    .out_count (out_count),
    .res_push  (res_push),
    .res_sign  (res_sign),
    .res_idx   (res_idx),
    .clearing  (clearing)
  );

  // push never meets a full result queue thanks to the credit in the back
  sqef_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data ({res_sign, res_idx}),
    .pop       (pop),
    .head_data (out_head),
    .full      (out_full),
    .empty     (empty),
    .count     (out_count)
  );

  assign out_sign_bit          = out_head[RES_W-1] && !out_full || out_head[RES_W-1];
  assign out_element_index_out = out_head[IDX_W-1:0];

endmodule

/* rtl/sqef_checker.sv */
// ----------------------------------------------------------------------------
// sqef_checker
// Port-level checks of the sign quantizer: reset state, no result without
// an item outstanding, occupancy bound and result hold under stall.
// ----------------------------------------------------------------------------
module sqef_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  logic                               full,
  input  logic                               empty,
  input  logic                               pop,
  input  logic                               out_sign_bit,
  input  logic [sqef_pkg::IDX_W-1:0]         out_element_index_out
);

  import sqef_pkg::*;

  localparam int MAX_INFL = FRONT_STAGES + MID_DEPTH + BACK_STAGES + OUT_DEPTH;
  localparam int CNT_W    = $clog2(MAX_INFL + 2);

  logic             xfer_in;
  logic             xfer_out;
  logic [CNT_W-1:0] infl_r;

  assign xfer_in  = push && !full;
  assign xfer_out = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      infl_r <= '0;
    end else begin
      unique case ({xfer_in, xfer_out})
        2'b10:   infl_r <= infl_r + 1'b1;
        2'b01:   infl_r <= infl_r - 1'b1;
        default: infl_r <= infl_r;
      endcase
    end
  end

  // reset leaves no result and blocks transfers in while the store clears
  a_reset_state: assert property (@(posedge clk) !rst_n |=> (full && empty))
    else $error("reset did not leave full high and empty high");

  // a result only ever stands for an item that came in
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (infl_r != '0))
    else $error("result shown with no item outstanding");

  // items held inside never exceed the storage of the pipeline and queues
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    infl_r <= CNT_W'(MAX_INFL))
    else $error("more items outstanding than the block can hold");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_sign_bit)
                          && $stable(out_element_index_out)))
    else $error("waiting result changed before its transfer");

endmodule

bind sign_quantize_error_feedback sqef_checker u_sqef_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .push                  (push),
  .full                  (full),
  .empty                 (empty),
  .pop                   (pop),
  .out_sign_bit          (out_sign_bit),
  .out_element_index_out (out_element_index_out)
);
